[src/mbst_pkg.sv]
package mbst_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned MARGIN_W = 12;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned OUT_W    = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MARGIN_COLS  = 2'd2,
    REG_MARGIN_ROWS  = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST  = 14'd4096;
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST = 14'd4096;
  localparam logic [MARGIN_W-1:0] MARGIN_COLS_RST  = 12'd1000;
  localparam logic [MARGIN_W-1:0] MARGIN_ROWS_RST  = 12'd700;

  // x / 10 == (x * 0xCCCD) >> 19, exact for every 16-bit x
  localparam int unsigned    DIV10_MUL_W = 16;
  localparam logic [15:0]    DIV10_MUL   = 16'hCCCD;
  localparam int unsigned    DIV10_SHIFT = 19;

endpackage

[src/mask_bounding_square_tracker.sv]
// Bounding square of the foreground in a raster mask stream.
//
// Input channel: one mask pixel per item (in_mask_value, in_frame_end), in raster
// order. Zero pixels strictly inside the margin window widen a min/max box. An
// item is taken at a clock edge with in_valid high and in_stall low.
// A frame ends on in_frame_end, or when the counters reach the last column of
// the last row of the configured frame size; that item yields one result item.
// Result channel: out_square_x/out_square_y (signed), out_square_side, out_box_found,
// taken when out_valid is high and out_stall low.
// Throughput: one pixel per clock while in_stall is low. The snapshot register
// loads at the edge that takes the frame's last pixel; extents, divide-by-ten
// multiply, padding and squaring follow, each in its own register stage.
// A stalled receiver only backs up that result pipeline; pixels keep flowing
// until it holds results from several frames, and in_stall rises only while
// its first stage is full and cannot move on.
// Configuration: cfg_index/cfg_data written at cfg_valid, always ready; write only
// while idle. Reset (rst_n low, synchronous) restores the register defaults,
// clears the counters, the box and the valid flag of every pipeline stage.
module mask_bounding_square_tracker #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [mbst_pkg::MASK_W-1:0]             in_mask_value,
  input  logic                                    in_frame_end,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mbst_pkg::OUT_W-1:0]       out_square_x,
  output logic signed [mbst_pkg::OUT_W-1:0]       out_square_y,
  output logic [mbst_pkg::OUT_W-1:0]              out_square_side,
  output logic                                    out_box_found,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mbst_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mbst_pkg::SIZE_W-1:0]             cfg_data
);
  import mbst_pkg::*;

  localparam int unsigned CW = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
  localparam int unsigned PW = COORD_BITS + DIV10_MUL_W;
  localparam int unsigned QW = PW - DIV10_SHIFT;
  localparam int unsigned RW = COORD_BITS + 3;
  localparam int unsigned EW = (RW > OUT_W) ? RW : OUT_W;

  // Configuration registers
  logic [SIZE_W-1:0]   frame_width_r, frame_height_r;
  logic [MARGIN_W-1:0] margin_cols_r, margin_rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      margin_cols_r  <= MARGIN_COLS_RST;
      margin_rows_r  <= MARGIN_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_MARGIN_COLS:  margin_cols_r  <= cfg_data[MARGIN_W-1:0];
        REG_MARGIN_ROWS:  margin_rows_r  <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame tracking state
  logic [COORD_BITS-1:0] col_count_r, row_count_r;
  logic [COORD_BITS-1:0] least_col_r, greatest_col_r, least_row_r, greatest_row_r;
  logic                  seen_any_r;
  logic [COORD_BITS-1:0] least_col_nxt, greatest_col_nxt, least_row_nxt, greatest_row_nxt;
  logic                  seen_any_nxt;

  logic                  in_fire, last_col, last_row, frame_done, fg_hit;
  logic [SIZE_W-1:0]     fw_m1, fh_m1;
  logic signed [CW-1:0]  col_s, row_s, col_hi, row_hi;

  assign in_fire = in_valid && !in_stall;
  assign fw_m1   = frame_width_r - SIZE_W'(1);
  assign fh_m1   = frame_height_r - SIZE_W'(1);
  assign last_col = CW'(col_count_r) == CW'(fw_m1);
  assign last_row = CW'(row_count_r) == CW'(fh_m1);
  assign frame_done = in_frame_end || (last_col && last_row);

  // Margin window test, signed so that an empty window admits nothing
  assign col_s  = CW'(col_count_r);
  assign row_s  = CW'(row_count_r);
  assign col_hi = CW'(frame_width_r) - CW'(margin_cols_r);
  assign row_hi = CW'(frame_height_r) - CW'(margin_rows_r);
  assign fg_hit = (in_mask_value == '0) &&
                  (col_s > CW'(margin_cols_r)) && (row_s > CW'(margin_rows_r)) &&
                  (col_s < col_hi) && (row_s < row_hi);

  // Box including the current pixel
  always_comb begin
    least_col_nxt    = least_col_r;
    greatest_col_nxt = greatest_col_r;
    least_row_nxt    = least_row_r;
    greatest_row_nxt = greatest_row_r;
    seen_any_nxt     = seen_any_r;
    if (fg_hit) begin
      if (col_count_r < least_col_r)    least_col_nxt    = col_count_r;
      if (col_count_r > greatest_col_r) greatest_col_nxt = col_count_r;
      if (row_count_r < least_row_r)    least_row_nxt    = row_count_r;
      if (row_count_r > greatest_row_r) greatest_row_nxt = row_count_r;
      seen_any_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r    <= '0;
      row_count_r    <= '0;
      least_col_r    <= '1;
      greatest_col_r <= '0;
      least_row_r    <= '1;
      greatest_row_r <= '0;
      seen_any_r     <= 1'b0;
    end else if (in_fire) begin
      if (frame_done) begin
        col_count_r    <= '0;
        row_count_r    <= '0;
        least_col_r    <= '1;
        greatest_col_r <= '0;
        least_row_r    <= '1;
        greatest_row_r <= '0;
        seen_any_r     <= 1'b0;
      end else begin
        least_col_r    <= least_col_nxt;
        greatest_col_r <= greatest_col_nxt;
        least_row_r    <= least_row_nxt;
        greatest_row_r <= greatest_row_nxt;
        seen_any_r     <= seen_any_nxt;
        if (last_col) begin
          col_count_r <= '0;
          row_count_r <= row_count_r + COORD_BITS'(1);
        end else begin
          col_count_r <= col_count_r + COORD_BITS'(1);
        end
      end
    end
  end

  // Result pipeline flow control
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic s1_ld, s2_ld, s3_ld, s4_ld, out_ld;

  assign out_ld = s4_v_r && (!out_valid_r || !out_stall);
  assign s4_ld  = s3_v_r && (!s4_v_r || out_ld);
  assign s3_ld  = s2_v_r && (!s3_v_r || s4_ld);
  assign s2_ld  = s1_v_r && (!s2_v_r || s3_ld);
  assign s1_ld  = in_fire && frame_done;
  assign in_stall = s1_v_r && !s2_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= (s1_v_r && !s2_ld) || s1_ld;
      s2_v_r      <= (s2_v_r && !s3_ld) || s2_ld;
      s3_v_r      <= (s3_v_r && !s4_ld) || s3_ld;
      s4_v_r      <= (s4_v_r && !out_ld) || s4_ld;
      out_valid_r <= (out_valid_r && out_stall) || out_ld;
    end
  end

  // Stage 1: final box of the frame
  logic [COORD_BITS-1:0] s1_lc_r, s1_gc_r, s1_lr_r, s1_gr_r;
  logic                  s1_found_r;

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_lc_r    <= least_col_nxt;
      s1_gc_r    <= greatest_col_nxt;
      s1_lr_r    <= least_row_nxt;
      s1_gr_r    <= greatest_row_nxt;
      s1_found_r <= seen_any_nxt;
    end
  end

  // Stage 2: extents
  logic [COORD_BITS-1:0] s2_w_r, s2_h_r, s2_lc_r, s2_lr_r;
  logic                  s2_found_r;

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      s2_w_r     <= s1_gc_r - s1_lc_r;
      s2_h_r     <= s1_gr_r - s1_lr_r;
      s2_lc_r    <= s1_lc_r;
      s2_lr_r    <= s1_lr_r;
      s2_found_r <= s1_found_r;
    end
  end

  // Stage 3: tenth of each extent by reciprocal multiply
  logic [PW-1:0]         s3_wp_r, s3_hp_r;
  logic [COORD_BITS-1:0] s3_w_r, s3_h_r, s3_lc_r, s3_lr_r;
  logic                  s3_found_r;

  always_ff @(posedge clk) begin
    if (s3_ld) begin
      s3_wp_r    <= PW'(s2_w_r) * PW'(DIV10_MUL);
      s3_hp_r    <= PW'(s2_h_r) * PW'(DIV10_MUL);
      s3_w_r     <= s2_w_r;
      s3_h_r     <= s2_h_r;
      s3_lc_r    <= s2_lc_r;
      s3_lr_r    <= s2_lr_r;
      s3_found_r <= s2_found_r;
    end
  end

  // Stage 4: padded extents and padded origin
  logic [QW-1:0]         wq, hq;
  logic signed [RW-1:0]  s4_pw_r, s4_ph_r, s4_x0_r, s4_y0_r;
  logic                  s4_found_r;

  assign wq = s3_wp_r[PW-1:DIV10_SHIFT];
  assign hq = s3_hp_r[PW-1:DIV10_SHIFT];

  always_ff @(posedge clk) begin
    if (s4_ld) begin
      s4_pw_r    <= RW'(s3_w_r) + RW'({wq, 1'b0});
      s4_ph_r    <= RW'(s3_h_r) + RW'({hq, 1'b0});
      s4_x0_r    <= RW'(s3_lc_r) - RW'(wq);
      s4_y0_r    <= RW'(s3_lr_r) - RW'(hq);
      s4_found_r <= s3_found_r;
    end
  end

  // Output stage: center the shorter side
  logic signed [RW-1:0] d_wh, d_hw, sq_x, sq_y, sq_side;
  logic signed [EW-1:0] sq_x_e, sq_y_e, sq_side_e;
  logic signed [OUT_W-1:0] out_x_r, out_y_r;
  logic [OUT_W-1:0]        out_side_r;
  logic                    out_found_r;

  assign d_wh = s4_pw_r - s4_ph_r;
  assign d_hw = s4_ph_r - s4_pw_r;

  always_comb begin
    if (!d_wh[RW-1]) begin
      sq_side = s4_pw_r;
      sq_x    = s4_x0_r;
      sq_y    = s4_y0_r - (d_wh >>> 1);
    end else begin
      sq_side = s4_ph_r;
      sq_x    = s4_x0_r - (d_hw >>> 1);
      sq_y    = s4_y0_r;
    end
  end

  assign sq_x_e    = EW'(sq_x);
  assign sq_y_e    = EW'(sq_y);
  assign sq_side_e = EW'(sq_side);

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_found_r <= s4_found_r;
      if (s4_found_r) begin
        out_x_r    <= sq_x_e[OUT_W-1:0];
        out_y_r    <= sq_y_e[OUT_W-1:0];
        out_side_r <= sq_side_e[OUT_W-1:0];
      end else begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_side_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_x    = out_x_r;
  assign out_square_y    = out_y_r;
  assign out_square_side = out_side_r;
  assign out_box_found   = out_found_r;

  // Checks
  a_done_snapshots: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && frame_done) |=> s1_v_r)
    else $error("frame end did not reach the result pipeline");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && frame_done) |=> (col_count_r == '0 && row_count_r == '0 && !seen_any_r))
    else $error("frame state not cleared after frame end");

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    seen_any_r |-> (least_col_r <= greatest_col_r && least_row_r <= greatest_row_r))
    else $error("box bounds out of order");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_box_found) |-> (out_square_side == '0 && out_square_x == '0))
    else $error("result without foreground is not zero");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r))
    else $error("input stalled while result pipeline has room");

endmodule

[tb/sv/tb_mask_bounding_square_tracker.sv]
`timescale 1ns / 100ps

module tb_mask_bounding_square_tracker;
  import mbst_pkg::*;

  localparam realtime CLK_PERIOD = 12.0;
  localparam int      COORD_W    = 13;
  localparam int      SETTLE_CYC = 10;       // result pipeline is 5 deep
  localparam int      HOLD_CYC   = 400;      // long receiver hold-off
  localparam int      CYCLE_LIMIT = 1000000;

  // One mask pixel as offered on the input channel
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              fend;
  } pixel_t;

  // One square box as expected on the result channel
  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic [OUT_W-1:0]        side;
    logic                    found;
  } square_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [MASK_W-1:0]        in_mask_value = '0;
  logic                     in_frame_end = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [OUT_W-1:0]  out_square_x;
  logic signed [OUT_W-1:0]  out_square_y;
  logic [OUT_W-1:0]         out_square_side;
  logic                     out_box_found;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  cfg_reg_t                 cfg_index = REG_FRAME_WIDTH;
  logic [SIZE_W-1:0]        cfg_data = '0;

  mask_bounding_square_tracker u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mask_value   (in_mask_value),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_square_x    (out_square_x),
    .out_square_y    (out_square_y),
    .out_square_side (out_square_side),
    .out_box_found   (out_box_found),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the frame registers
  logic [SIZE_W-1:0]   frame_w  = FRAME_WIDTH_RST;
  logic [SIZE_W-1:0]   frame_h  = FRAME_HEIGHT_RST;
  logic [MARGIN_W-1:0] margin_c = MARGIN_COLS_RST;
  logic [MARGIN_W-1:0] margin_r = MARGIN_ROWS_RST;

  // Raster position and running foreground box
  logic [COORD_W-1:0] col_pos    = '0;
  logic [COORD_W-1:0] row_pos    = '0;
  logic [COORD_W-1:0] box_left   = '1;
  logic [COORD_W-1:0] box_right  = '0;
  logic [COORD_W-1:0] box_top    = '1;
  logic [COORD_W-1:0] box_bottom = '0;
  logic               box_seen   = 1'b0;

  pixel_t  pixel_q[$];
  square_t square_q[$];
  int      queued_cnt   = 0;
  int      accepted_cnt = 0;
  int      mismatches   = 0;
  int      cycles       = 0;

  // Driver pacing
  int burst_left = 1;
  int gap_left   = 0;

  // Receiver pattern and hold-off
  logic pressure_on = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;
  int   stall_mode  = 0;
  logic [7:0] pat_cnt = '0;

  // Advance the raster position by one pixel; queue a square at frame end
  task automatic track_pixel(input logic [MASK_W-1:0] mv, input logic fend);
    logic [SIZE_W-1:0] w_last, h_last;
    logic              at_last_col, at_last_row, done;
    int                c, r, w, h, pw, ph, x, y, side;
    square_t           sq;
    w_last      = frame_w - 14'd1;
    h_last      = frame_h - 14'd1;
    at_last_col = ({1'b0, col_pos} == w_last);
    at_last_row = ({1'b0, row_pos} == h_last);
    done        = fend || (at_last_col && at_last_row);
    c = int'(col_pos);
    r = int'(row_pos);

    // foreground only counts strictly inside the margin window
    if (mv == '0 && c > int'(margin_c) && r > int'(margin_r) &&
        c < int'(frame_w) - int'(margin_c) &&
        r < int'(frame_h) - int'(margin_r)) begin
      if (col_pos < box_left)   box_left   = col_pos;
      if (col_pos > box_right)  box_right  = col_pos;
      if (row_pos < box_top)    box_top    = row_pos;
      if (row_pos > box_bottom) box_bottom = row_pos;
      box_seen = 1'b1;
    end

    if (!done) begin
      if (at_last_col) begin
        col_pos = '0;
        row_pos = row_pos + COORD_W'(1);
      end else begin
        col_pos = col_pos + COORD_W'(1);
      end
    end else begin
      x = 0;
      y = 0;
      side = 0;
      if (box_seen) begin
        w  = int'(box_right) - int'(box_left);
        h  = int'(box_bottom) - int'(box_top);
        pw = w + 2 * (w / 10);
        ph = h + 2 * (h / 10);
        x  = int'(box_left) - w / 10;
        y  = int'(box_top) - h / 10;
        // center the shorter side on the longer one
        if (pw >= ph) begin
          side = pw;
          y    = y - (pw - ph) / 2;
        end else begin
          side = ph;
          x    = x - (ph - pw) / 2;
        end
      end
      sq.x     = x[OUT_W-1:0];
      sq.y     = y[OUT_W-1:0];
      sq.side  = side[OUT_W-1:0];
      sq.found = box_seen;
      square_q.push_back(sq);
      col_pos    = '0;
      row_pos    = '0;
      box_left   = '1;
      box_right  = '0;
      box_top    = '1;
      box_bottom = '0;
      box_seen   = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Input driver: bursts of random length with random gaps
  always @(posedge clk) begin : drive
    pixel_t px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_pixel(in_mask_value, in_frame_end);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          px = pixel_q.pop_front();
          in_mask_value <= px.mask;
          in_frame_end  <= px.fend;
          in_valid      <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: mode is redrawn whenever pat_cnt[5:0] wraps to zero; one long hold under pressure
  always @(posedge clk) begin : recv
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!pressure_on) hold_done = 1'b0;
      if (pressure_on && !hold_done) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      pat_cnt = pat_cnt + 8'd1;
      if (pat_cnt[5:0] == '0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= pat_cnt[2];
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check
    square_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (square_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item x=%0d y=%0d side=%0d found=%0b",
                                out_square_x, out_square_y, out_square_side,
                                out_box_found));
      end else begin
        want = square_q.pop_front();
        if (out_square_x !== want.x)
          flag_mismatch($sformatf("square_x expected %0d got %0d", want.x, out_square_x));
        if (out_square_y !== want.y)
          flag_mismatch($sformatf("square_y expected %0d got %0d", want.y, out_square_y));
        if (out_square_side !== want.side)
          flag_mismatch($sformatf("square_side expected %0d got %0d",
                                  want.side, out_square_side));
        if (out_box_found !== want.found)
          flag_mismatch($sformatf("box_found expected %0b got %0b",
                                  want.found, out_box_found));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** mask_bounding_square_tracker: FAILED **");
      $finish;
    end
  end

  task automatic push_pixel(input logic [MASK_W-1:0] mv, input logic fe);
    pixel_t px;
    px.mask = mv;
    px.fend = fe;
    pixel_q.push_back(px);
    queued_cnt++;
  endtask

  // Leaves the configuration channel valid until its handshake
  task automatic write_reg(input cfg_reg_t idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  frame_w  = val;
      REG_FRAME_HEIGHT: frame_h  = val;
      REG_MARGIN_COLS:  margin_c = val[MARGIN_W-1:0];
      REG_MARGIN_ROWS:  margin_r = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [SIZE_W-1:0] mc, input logic [SIZE_W-1:0] mr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_MARGIN_COLS, mc);
    write_reg(REG_MARGIN_ROWS, mr);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued pixel is taken and every square has come out
  task automatic drain();
    do @(posedge clk); while (accepted_cnt != queued_cnt || square_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // One frame: mostly a full raster, sometimes cut short by frame_end
  task automatic add_frame(input int pct, input int cap);
    int   full, len, k;
    logic fe_last, fe;
    logic [MASK_W-1:0] mv;
    full = (frame_w >= 1 && frame_w <= 8192 && frame_h >= 1 && frame_h <= 8192) ?
           int'(frame_w) * int'(frame_h) : 0;
    if (full != 0 && full <= cap && $urandom_range(0, 3) != 0) begin
      len     = full;
      fe_last = $urandom_range(0, 1);
    end else begin
      len     = $urandom_range(1, (full != 0 && full < cap) ? full : cap);
      fe_last = 1'b1;
    end
    for (k = 0; k < len; k++) begin
      fe = (k == len - 1) ? fe_last : ($urandom_range(0, 99) == 0);
      mv = ($urandom_range(0, 99) < pct) ? 8'd0 : 8'($urandom_range(1, 255));
      push_pixel(mv, fe);
    end
  endtask

  function automatic int pick_density();
    case ($urandom_range(0, 2))
      0: return 5;
      1: return 30;
      default: return 70;
    endcase
  endfunction

  task automatic random_phase(input int kind);
    int start;
    case (kind)
      4: set_frame(14'($urandom_range(12, 28)), 14'($urandom_range(12, 24)),
                   14'($urandom_range(0, 2)), 14'($urandom_range(0, 2)));
      5: set_frame(14'd1, 14'd8192, 14'd0, 14'd0);
      6: set_frame(($urandom_range(0, 1) != 0) ? 14'd0 : 14'($urandom_range(8193, 16383)),
                   14'd1, 14'd4095, 14'd4095);
      7: set_frame(14'($urandom_range(3, 10)), 14'd1, 14'($urandom_range(0, 2)), 14'd0);
      8: set_frame(14'($urandom_range(4, 10)), 14'($urandom_range(4, 10)),
                   14'($urandom_range(2, 5)), 14'($urandom_range(0, 5)));
      default: set_frame(14'($urandom_range(2, 16)), 14'($urandom_range(2, 14)),
                         14'($urandom_range(0, 3)), 14'($urandom_range(0, 3)));
    endcase
    start = queued_cnt;
    while (queued_cnt - start < 60) add_frame(pick_density(), 160);
    push_pixel(8'($urandom_range(0, 255)), 1'b1);
    drain();
  endtask

  initial begin : stimulus
    int k, p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: single-pixel frames, background and a zero pixel at origin outside the reset margins
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b1);
    drain();

    // 3x3 frame, no margin: full raster ending on its own
    set_frame(14'd3, 14'd3, 14'd0, 14'd0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hAA, 1'b0);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h7F, 1'b0);
    push_pixel(8'h00, 1'b0);
    // frame cut short by frame_end on a lone foreground pixel
    push_pixel(8'hFE, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b1);
    drain();

    // zero width never matches the last column
    set_frame(14'd0, 14'd2, 14'd0, 14'd0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h00, 1'b1);
    drain();

    // wide column margin on a flat box: box lands at a negative row
    set_frame(14'd64, 14'd64, 14'd20, 14'd0);
    for (k = 0; k < 64; k++) push_pixel(8'($urandom_range(0, 255)), 1'b0);
    for (k = 0; k < 44; k++) begin
      if (k == 20 || k == 21 || k == 43)
        push_pixel(8'h00, k == 43);
      else
        push_pixel(8'($urandom_range(1, 255)), 1'b0);
    end
    drain();

    // random configurations and frames
    for (p = 0; p < 10; p++) begin
      random_phase((p < 9) ? p : $urandom_range(0, 8));
      // back-pressure: tiny frames while the receiver holds off
      if (p == 4) begin
        set_frame(14'd3, 14'd3, 14'd0, 14'd0);
        while (pixel_q.size() < 150) add_frame(50, 9);
        push_pixel(8'h00, 1'b1);
        pressure_on <= 1'b1;
        drain();
        pressure_on <= 1'b0;
      end
    end

    if (mismatches == 0) begin
      $display("** mask_bounding_square_tracker: PASSED **");
    end else begin
      $display("** mask_bounding_square_tracker: FAILED **");
    end
    $finish;
  end

endmodule
